// ===== src/sfd_pkg.sv =====
// Shared constants and helpers for the sentence frame decoder.
package sfd_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 128;

    localparam logic [7:0] CH_START  = 8'h24;  // '$'
    localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
    localparam logic [7:0] CH_NL     = 8'h0A;  // newline

    localparam logic [23:0] TAG_DET = 24'h444554;
    localparam logic [23:0] TAG_CHA = 24'h434841;
    localparam logic [23:0] TAG_COO = 24'h434F4F;
    localparam logic [23:0] TAG_HIT = 24'h484954;

    localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;
    localparam logic [7:0] HEX_LOWER_OFS = 8'd87;
    localparam logic [7:0] HEX_UPPER_OFS = 8'd55;

    localparam logic [2:0] ST_WAITING = 3'd0;
    localparam logic [2:0] ST_GOOD    = 3'd1;
    localparam logic [2:0] ST_FAIL    = 3'd2;
    localparam logic [2:0] ST_DET     = 3'd3;
    localparam logic [2:0] ST_CHA     = 3'd4;
    localparam logic [2:0] ST_COO     = 3'd5;
    localparam logic [2:0] ST_HIT     = 3'd6;

    typedef struct packed {
        logic       valid;
        logic [3:0] nibble;
    } t_hex;

    // Decodes one ASCII hex digit; valid is low for any other byte.
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex       r;
        logic [7:0] d;
        d = 8'd0;
        r.valid = 1'b1;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - HEX_DIGIT_OFS;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - HEX_LOWER_OFS;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - HEX_UPPER_OFS;
        end else begin
            r.valid = 1'b0;
        end
        r.nibble = d[3:0];
        return r;
    endfunction

endpackage

// ===== src/sentence_frame_decoder.sv =====
// Sentence frame decoder: frames $payload*HH newline and reports a status per byte.
// Each accepted word passes through the input register and then the result register.
// Throughput: one word per cycle while the output is free; the input register feeds the frame
// state update, which writes the result register, and both advance whenever the output is free.
// Reset (synchronous, active low) returns the framer to waiting and empties both stages.
module sentence_frame_decoder
    import sfd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [2:0] status, [3] checksum_ok,
                                          // [11:4] received_checksum, [15:12] zero
);

    localparam logic [2:0] PH_WAIT = 3'd0;
    localparam logic [2:0] PH_REC  = 3'd1;
    localparam logic [2:0] PH_HEX1 = 3'd2;
    localparam logic [2:0] PH_HEX2 = 3'd3;
    localparam logic [2:0] PH_NL   = 3'd4;

    localparam logic [7:0] MAX_CNT = 8'(MAX_PAYLOAD);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic        r_out_ok;
    logic [7:0]  r_out_cksum;

    logic [2:0]  r_phase,  n_phase;
    logic [7:0]  r_count,  n_count;
    logic [7:0]  r_xor,    n_xor;
    logic [7:0]  r_cksum,  n_cksum;
    logic [15:0] r_prev,   n_prev;
    logic [3:0]  r_tags,   n_tags;
    logic        r_stop,   n_stop;
    logic [2:0]  n_status;
    logic        n_ok;

    logic        out_free;
    logic        fire;
    logic [23:0] triple;
    t_hex        hx;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_cksum, r_out_ok, r_out_status};

    assign triple = {r_prev, r_in_byte};
    assign hx     = hex_decode(r_in_byte);

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_xor    = r_xor;
        n_cksum  = r_cksum;
        n_prev   = r_prev;
        n_tags   = r_tags;
        n_stop   = r_stop;
        n_status = ST_GOOD;
        n_ok     = 1'b0;
        case (r_phase)
            PH_REC: begin
                if (r_in_byte == CH_STAR) begin
                    n_phase = PH_HEX1;
                end else if (r_count >= MAX_CNT) begin
                    n_status = ST_FAIL;
                    n_phase  = PH_WAIT;
                end else begin
                    n_count = r_count + 8'd1;
                    n_xor   = r_xor ^ r_in_byte;
                    if (r_in_byte == 8'd0) begin
                        n_stop = 1'b1;
                    end else if (!r_stop) begin
                        n_tags = r_tags | {triple == TAG_HIT, triple == TAG_COO,
                                           triple == TAG_CHA, triple == TAG_DET};
                    end
                    n_prev = {r_prev[7:0], r_in_byte};
                end
            end
            PH_HEX1: begin
                if (hx.valid) begin
                    n_cksum = {hx.nibble, 4'd0};
                    n_phase = PH_HEX2;
                end else begin
                    n_status = ST_FAIL;
                    n_phase  = PH_WAIT;
                end
            end
            PH_HEX2: begin
                if (hx.valid) begin
                    n_cksum = {r_cksum[7:4], hx.nibble};
                    n_phase = PH_NL;
                end else begin
                    n_status = ST_FAIL;
                    n_phase  = PH_WAIT;
                end
            end
            PH_NL: begin
                if (r_in_byte == CH_NL) begin
                    n_ok = (r_cksum == r_xor);
                    if (r_tags[0]) begin
                        n_status = ST_DET;
                    end else if (r_tags[1]) begin
                        n_status = ST_CHA;
                    end else if (r_tags[2]) begin
                        n_status = ST_COO;
                    end else if (r_tags[3]) begin
                        n_status = ST_HIT;
                    end else begin
                        n_status = ST_FAIL;
                    end
                end else begin
                    n_status = ST_FAIL;
                end
                n_phase = PH_WAIT;
            end
            default: begin
                // Unused phase codes behave as waiting.
                if (r_in_byte == CH_START) begin
                    n_count = 8'd0;
                    n_xor   = 8'd0;
                    n_cksum = 8'd0;
                    n_prev  = 16'd0;
                    n_tags  = 4'd0;
                    n_stop  = 1'b0;
                    n_phase = PH_REC;
                end else begin
                    n_status = ST_WAITING;
                    n_phase  = PH_WAIT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_WAIT;
            r_count     <= 8'd0;
            r_xor       <= 8'd0;
            r_cksum     <= 8'd0;
            r_prev      <= 16'd0;
            r_tags      <= 4'd0;
            r_stop      <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_xor   <= n_xor;
                r_cksum <= n_cksum;
                r_prev  <= n_prev;
                r_tags  <= n_tags;
                r_stop  <= n_stop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (fire) begin
            r_out_status <= n_status;
            r_out_ok     <= n_ok;
            r_out_cksum  <= n_cksum;
        end
    end

endmodule

// ===== bench/sentence_frame_decoder_checker.sv =====
// Checker for the sentence frame decoder: predicts each result word and compares it field by field.
`timescale 1ns / 1ps
module sentence_frame_decoder_checker
    import sfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] rx_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,    // [2:0] status, [3] checksum_ok,
                                      // [11:4] received_checksum, [15:12] zero
    output int          o_fail_count,
    output int          o_pending
);

    localparam int unsigned BODY_MAX = MAX_PAYLOAD_DEF;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_SUM_HI,
        PH_SUM_LO,
        PH_EOL
    } t_frame_phase;

    typedef struct packed {
        logic [2:0] status;
        logic       sum_ok;
        logic [7:0] rx_sum;
    } t_frame_result;

    t_frame_phase  phase;
    logic [7:0]    body_len;
    logic [7:0]    body_xor;
    logic [7:0]    rx_sum;
    logic [15:0]   last_two;
    logic [3:0]    tags_found;     // bit 0 DET, 1 CHA, 2 COO, 3 HIT
    logic          search_off;
    t_frame_result result_q[$];

    initial o_fail_count = 0;

    // Bit 4 is set when the byte is not an ASCII hex digit.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return 5'b10000;
    endfunction

    task automatic clear_frame();
        body_len   = 8'h00;
        body_xor   = 8'h00;
        rx_sum     = 8'h00;
        last_two   = 16'h0000;
        tags_found = 4'h0;
        search_off = 1'b0;
    endtask

    task automatic decode_byte(input logic [7:0] c, output t_frame_result r);
        logic [4:0] nib;
        r.status = ST_GOOD;
        r.sum_ok = 1'b0;
        case (phase)
            PH_BODY: begin
                if (c == CH_STAR) begin
                    phase = PH_SUM_HI;
                end else if (body_len >= BODY_MAX) begin
                    r.status = ST_FAIL;
                    phase    = PH_IDLE;
                end else begin
                    body_len = body_len + 8'd1;
                    body_xor = body_xor ^ c;
                    // A zero byte ends the tag search for the rest of the payload.
                    if (c == 8'h00) begin
                        search_off = 1'b1;
                    end else if (!search_off) begin
                        if ({last_two, c} == TAG_DET) tags_found[0] = 1'b1;
                        if ({last_two, c} == TAG_CHA) tags_found[1] = 1'b1;
                        if ({last_two, c} == TAG_COO) tags_found[2] = 1'b1;
                        if ({last_two, c} == TAG_HIT) tags_found[3] = 1'b1;
                    end
                    last_two = {last_two[7:0], c};
                end
            end
            PH_SUM_HI: begin
                nib = nibble_of(c);
                if (nib[4]) begin
                    r.status = ST_FAIL;
                    phase    = PH_IDLE;
                end else begin
                    rx_sum = {nib[3:0], 4'h0};
                    phase  = PH_SUM_LO;
                end
            end
            PH_SUM_LO: begin
                nib = nibble_of(c);
                if (nib[4]) begin
                    r.status = ST_FAIL;
                    phase    = PH_IDLE;
                end else begin
                    rx_sum = {rx_sum[7:4], nib[3:0]};
                    phase  = PH_EOL;
                end
            end
            PH_EOL: begin
                if (c == CH_NL) begin
                    r.sum_ok = (rx_sum == body_xor);
                    if (tags_found[0]) r.status = ST_DET;
                    else if (tags_found[1]) r.status = ST_CHA;
                    else if (tags_found[2]) r.status = ST_COO;
                    else if (tags_found[3]) r.status = ST_HIT;
                    else r.status = ST_FAIL;
                end else begin
                    r.status = ST_FAIL;
                end
                phase = PH_IDLE;
            end
            default: begin
                if (c == CH_START) begin
                    clear_frame();
                    phase = PH_BODY;
                end else begin
                    r.status = ST_WAITING;
                    phase    = PH_IDLE;
                end
            end
        endcase
        r.rx_sum = rx_sum;
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_frame_result want;
        t_frame_result got;
        if (!i_rst_n) begin
            clear_frame();
            phase = PH_IDLE;
            result_q.delete();
        end else begin
            // A result word always belongs to an earlier input word, so check first.
            if (i_m_tvalid && i_m_tready) begin
                got.status = i_m_tdata[2:0];
                got.sum_ok = i_m_tdata[3];
                got.rx_sum = i_m_tdata[11:4];
                if (result_q.size() == 0) begin
                    report_mismatch($sformatf("result word %h with nothing expected", i_m_tdata));
                end else begin
                    want = result_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.sum_ok != want.sum_ok)
                        report_mismatch($sformatf("checksum_ok %0b, expected %0b",
                                                  got.sum_ok, want.sum_ok));
                    if (got.rx_sum != want.rx_sum)
                        report_mismatch($sformatf("received_checksum %h, expected %h",
                                                  got.rx_sum, want.rx_sum));
                    if (i_m_tdata[15:12] != 4'h0)
                        report_mismatch($sformatf("padding bits %h, expected zero",
                                                  i_m_tdata[15:12]));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_byte(i_s_tdata, want);
                result_q.push_back(want);
            end
        end
        o_pending <= result_q.size();
    end

endmodule

// ===== bench/sentence_frame_decoder_test.sv =====
// Top of the sentence frame decoder test: clock, reset, byte stimulus, idling and the verdict.
`timescale 1ns / 1ps
module sentence_frame_decoder_test;
    import sfd_pkg::*;

    localparam int RANDOM_WORDS = 420;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;            // [2:0] status, [3] checksum_ok,
                                            // [11:4] received_checksum, [15:12] zero
    int          fail_count;
    int          pending;
    int          tx_idle_pct  = 33;
    int          rx_idle_pct  = 57;
    int          words_sent   = 0;
    int          stall_cycles = 0;
    logic [7:0]  line_q[$];
    string       tag_text[4]  = '{"DET", "CHA", "COO", "HIT"};
    string       bad_hex      = "gG/:@`Zz \n";

    sentence_frame_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    sentence_frame_decoder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("sentence_frame_decoder_test: FAIL");
            $finish;
        end
    end

    // Returns at the clock edge that accepts the word.
    task automatic send_char(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(negedge i_clk);
        while (!o_s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        // Letters come in either case, 'a' or 'A' plus the offset.
        return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    // A negative body size asks for a random line (noise bytes or a sentence, often malformed, with a
    // short payload); any other value gives a sentence with exactly that many payload bytes and a bad checksum.
    task automatic build_sentence(input int body_size);
        logic [7:0] body[$];
        logic [7:0] sum;
        logic [7:0] b;
        int         kind;
        string      t;
        kind = (body_size < 0) ? int'($urandom_range(99)) : 99;
        line_q.delete();
        if (kind < 8) begin
            repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(255)));
            return;
        end
        if (body_size < 0) body_size = $urandom_range(12);
        while (body.size() < body_size) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    t = tag_text[$urandom_range(3)];
                    for (int i = 0; i < 3 && body.size() < body_size; i++) body.push_back(t[i]);
                end
                3: body.push_back(($urandom_range(3) == 0) ? 8'h00 : CH_START);
                default: begin
                    b = 8'($urandom_range(255));
                    body.push_back((b == CH_STAR) ? 8'h2B : b);
                end
            endcase
        end
        sum = 8'h00;
        line_q.push_back(CH_START);
        foreach (body[i]) begin
            sum ^= body[i];
            line_q.push_back(body[i]);
        end
        // A sentence cut off here leaves the next start character inside its payload.
        if (kind < 12) return;
        line_q.push_back(CH_STAR);
        if (kind >= 85) sum ^= 8'($urandom_range(1, 255));
        if (kind < 18) begin
            b = bad_hex[$urandom_range(bad_hex.len() - 1)];
            if ($urandom_range(1)) line_q.push_back(hex_char(sum[7:4]));
            line_q.push_back(b);
            return;
        end
        line_q.push_back(hex_char(sum[7:4]));
        line_q.push_back(hex_char(sum[3:0]));
        if (kind < 24) begin
            b = 8'($urandom_range(255));
            line_q.push_back((b == CH_NL) ? CH_START : b);
        end else begin
            line_q.push_back(CH_NL);
        end
    endtask

    initial begin
        int first_random;
        int n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Noise while waiting, a clean sentence, bad hex, an empty payload with
        // no newline, and a zero byte hiding a tag.
        send_char(8'hFF);
        send_char(8'h00);
        send_text("$DET*55\n");
        send_text("$HIT*g");
        send_text("$*0Fx");
        send_char(CH_START);
        send_char(8'h00);
        send_text("CHA*7b\n");

        first_random = words_sent;
        n = 0;
        while (words_sent - first_random < RANDOM_WORDS) begin
            if (words_sent - first_random >= 2 * RANDOM_WORDS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (words_sent - first_random >= RANDOM_WORDS / 3) begin
                tx_idle_pct = 57;
                rx_idle_pct = 33;
            end
            // Two long payloads: one at the size limit and one just past it.
            if (n == 3 || n == 20) begin
                build_sentence((n == 3) ? MAX_PAYLOAD_DEF : MAX_PAYLOAD_DEF + 1);
            end else begin
                build_sentence(-1);
            end
            foreach (line_q[i]) send_char(line_q[i]);
            n++;
        end

        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("sentence_frame_decoder_test: PASS");
        end else begin
            $display("sentence_frame_decoder_test: FAIL");
        end
        $finish;
    end

endmodule
